[sv/rpm_pkg.sv]
// ---------------------------------------------------------------------------
// rpm_pkg
// Shared types, constants and decay tables for the rain pulse multiplier.
// ---------------------------------------------------------------------------
package rpm_pkg;

    localparam int RPM_WINDOW_DAYS = 15;
    localparam int RPM_LOW_DAYS    = 2;
    localparam int RPM_MID_DAYS    = 6;
    localparam int RPM_HIGH_DAYS   = 13;

    localparam int PRECIP_W   = 16;
    localparam int MULT_W     = 16;
    localparam int LIMIT_W    = 20;
    localparam int THRESH_W   = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [MULT_W-1:0] ONE_Q12 = 16'd4096;

    localparam logic [LIMIT_W-1:0]  RST_QUIET_LIMIT     = 20'd1000;
    localparam logic [THRESH_W-1:0] RST_START_THRESHOLD = 16'd100;
    localparam logic [THRESH_W-1:0] RST_MEDIUM_LOW      = 16'd500;
    localparam logic [THRESH_W-1:0] RST_MEDIUM_HIGH     = 16'd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUIET_LIMIT     = 2'd0,
        REG_START_THRESHOLD = 2'd1,
        REG_MEDIUM_LOW      = 2'd2,
        REG_MEDIUM_HIGH     = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CLASS_LOW  = 2'd0,
        CLASS_MID  = 2'd1,
        CLASS_HIGH = 2'd2
    } t_rain_class;

    // per-ring control: advance one day, and reload the decay curve
    typedef struct packed {
        logic shift;
        logic refill;
    } t_ring_ctl;

    // a*exp(-k*(n+1)) in Q4.12, n = table index
    function automatic logic [MULT_W-1:0] rpm_decay_value(t_rain_class cls, int idx);
        logic [MULT_W-1:0] v;
        v = '0;
        case (cls)
            CLASS_LOW: begin
                case (idx & 15)
                    0: v = 16'd5128;  1: v = 16'd2292;  2: v = 16'd1025;  3: v = 16'd458;
                    4: v = 16'd205;   5: v = 16'd92;    6: v = 16'd41;    7: v = 16'd18;
                    8: v = 16'd8;     9: v = 16'd4;     10: v = 16'd2;    11: v = 16'd1;
                    default: v = '0;
                endcase
            end
            CLASS_MID: begin
                case (idx & 31)
                    0: v = 16'd10239; 1: v = 16'd6974;  2: v = 16'd4750;  3: v = 16'd3236;
                    4: v = 16'd2204;  5: v = 16'd1501;  6: v = 16'd1022;  7: v = 16'd696;
                    8: v = 16'd474;   9: v = 16'd323;   10: v = 16'd220;  11: v = 16'd150;
                    12: v = 16'd102;  13: v = 16'd70;   14: v = 16'd47;   15: v = 16'd32;
                    16: v = 16'd22;   17: v = 16'd15;   18: v = 16'd10;   19: v = 16'd7;
                    20: v = 16'd5;    21: v = 16'd3;    22: v = 16'd2;    23: v = 16'd1;
                    24: v = 16'd1;    25: v = 16'd1;
                    default: v = '0;
                endcase
            end
            CLASS_HIGH: begin
                case (idx & 31)
                    0: v = 16'd15353; 1: v = 16'd12470; 2: v = 16'd10128; 3: v = 16'd8226;
                    4: v = 16'd6681;  5: v = 16'd5427;  6: v = 16'd4408;  7: v = 16'd3580;
                    8: v = 16'd2908;  9: v = 16'd2362;  10: v = 16'd1918; 11: v = 16'd1558;
                    12: v = 16'd1265; 13: v = 16'd1028; 14: v = 16'd835;  15: v = 16'd678;
                    16: v = 16'd551;  17: v = 16'd447;  18: v = 16'd363;  19: v = 16'd295;
                    20: v = 16'd240;  21: v = 16'd195;  22: v = 16'd158;  23: v = 16'd128;
                    24: v = 16'd104;  25: v = 16'd85;   26: v = 16'd69;   27: v = 16'd56;
                    28: v = 16'd45;   29: v = 16'd37;   30: v = 16'd30;   31: v = 16'd24;
                    default: v = '0;
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/rpm_decay_cell.sv]
// ---------------------------------------------------------------------------
// rpm_decay_cell
// One day slot of a decay ring: takes its neighbor's value on a shift, or
// its own curve value when the ring is reloaded.
// ---------------------------------------------------------------------------
module rpm_decay_cell
    import rpm_pkg::*;
#(
    parameter logic [MULT_W-1:0] LOAD_VAL = ONE_Q12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_ctl         i_ctl,
    input  logic [MULT_W-1:0] i_from_next,
    output logic [MULT_W-1:0] o_value
);

    logic [MULT_W-1:0] r_value;
    logic [MULT_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift) begin
            n_value = i_ctl.refill ? LOAD_VAL : i_from_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= ONE_Q12;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

[sv/rpm_decay_ring.sv]
// ---------------------------------------------------------------------------
// rpm_decay_ring
// Row of decay cells; cell 0 is today's slot, the slot that leaves the head
// re-enters at the tail as 1.0.
// ---------------------------------------------------------------------------
module rpm_decay_ring
    import rpm_pkg::*;
#(
    parameter int          DAYS       = RPM_LOW_DAYS,
    parameter t_rain_class RING_CLASS = CLASS_LOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_ctl         i_ctl,
    output logic [MULT_W-1:0] o_head
);

    logic [MULT_W-1:0] w_val  [DAYS];
    logic [MULT_W-1:0] w_next [DAYS];

    for (genvar g = 0; g < DAYS; g++) begin : g_cell
        localparam logic [MULT_W-1:0] LOAD_VAL =
            (g + 1 < DAYS) ? rpm_decay_value(RING_CLASS, g + 1) : ONE_Q12;

        if (g + 1 < DAYS) begin : g_mid
            assign w_next[g] = w_val[g+1];
        end else begin : g_tail
            assign w_next[g] = ONE_Q12;
        end

        rpm_decay_cell #(
            .LOAD_VAL (LOAD_VAL)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_from_next (w_next[g]),
            .o_value     (w_val[g])
        );
    end

    // head as seen after a same-day reload
    assign o_head = i_ctl.refill ? rpm_decay_value(RING_CLASS, 0) : w_val[0];

endmodule

[sv/rpm_rain_window.sv]
// ---------------------------------------------------------------------------
// rpm_rain_window
// Shift line of daily rain with a running sum; gives the sum of the days
// before today.
// ---------------------------------------------------------------------------
module rpm_rain_window
    import rpm_pkg::*;
#(
    parameter int WINDOW_DAYS = RPM_WINDOW_DAYS,
    parameter int SUM_W       = PRECIP_W + $clog2(WINDOW_DAYS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [PRECIP_W-1:0] i_precip,
    output logic [SUM_W-1:0]    o_quiet_sum
);

    logic [PRECIP_W-1:0] r_line [WINDOW_DAYS];
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;

    // oldest day drops out at the far end of the line
    assign o_quiet_sum = r_sum - SUM_W'(r_line[WINDOW_DAYS-1]);
    assign n_sum       = o_quiet_sum + SUM_W'(i_precip);

    for (genvar g = 0; g < WINDOW_DAYS; g++) begin : g_tap
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_line[g] <= '0;
            end else if (i_shift) begin
                if (g == 0) begin
                    r_line[g] <= i_precip;
                end else begin
                    r_line[g] <= r_line[(g == 0) ? 0 : g - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

endmodule

[sv/rain_pulse_multiplier.sv]
// ---------------------------------------------------------------------------
// rain_pulse_multiplier
// Daily emission pulse multiplier driven by rain events after dry spells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one request per day (i_precip, i_snow_present) on
//   i_in_valid / o_in_stall. Output channel: one Q4.12 multiplier per
//   request on o_out_valid / i_out_stall, in request order.
//   A request's result is registered in the output register at the edge
//   that takes it. Throughput is one request per cycle while o_in_stall
//   is low; day state lives in shift cells, a running rain sum and a pulse
//   countdown, so every cell moves by one position per accepted request.
//   o_in_stall is high only while the output register holds a result the
//   receiver is stalling; a taken result frees room in the same cycle.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered
//   and are meant for idle periods.
//   Reset (synchronous, i_rst_n low) empties the output register, clears
//   the rain history and pulse countdown, sets every decay slot to 1.0 and
//   loads the register defaults. No clearing pass is needed.
// ---------------------------------------------------------------------------
module rain_pulse_multiplier
    import rpm_pkg::*;
#(
    parameter int WINDOW_DAYS = RPM_WINDOW_DAYS,
    parameter int LOW_DAYS    = RPM_LOW_DAYS,
    parameter int MID_DAYS    = RPM_MID_DAYS,
    parameter int HIGH_DAYS   = RPM_HIGH_DAYS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input requests
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PRECIP_W-1:0]   i_precip,
    input  logic                  i_snow_present,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [MULT_W-1:0]     o_multiplier,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W    = PRECIP_W + $clog2(WINDOW_DAYS);
    localparam int CMP_W    = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam int MAX_LM   = (LOW_DAYS > MID_DAYS) ? LOW_DAYS : MID_DAYS;
    localparam int MAX_DAYS = (MAX_LM > HIGH_DAYS) ? MAX_LM : HIGH_DAYS;
    localparam int DAYS_W   = $clog2(MAX_DAYS + 1);

    // configuration registers
    logic [LIMIT_W-1:0]  r_quiet_limit;
    logic [THRESH_W-1:0] r_start_threshold;
    logic [THRESH_W-1:0] r_medium_low;
    logic [THRESH_W-1:0] r_medium_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_limit     <= RST_QUIET_LIMIT;
            r_start_threshold <= RST_START_THRESHOLD;
            r_medium_low      <= RST_MEDIUM_LOW;
            r_medium_high     <= RST_MEDIUM_HIGH;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_QUIET_LIMIT:     r_quiet_limit     <= i_cfg_data[LIMIT_W-1:0];
                REG_START_THRESHOLD: r_start_threshold <= i_cfg_data[THRESH_W-1:0];
                REG_MEDIUM_LOW:      r_medium_low      <= i_cfg_data[THRESH_W-1:0];
                REG_MEDIUM_HIGH:     r_medium_high     <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: output register frees on take, so stall only when it stays full
    logic r_out_valid;
    logic w_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // rain history
    logic [SUM_W-1:0] w_quiet_sum;

    rpm_rain_window #(
        .WINDOW_DAYS (WINDOW_DAYS),
        .SUM_W       (SUM_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (w_accept),
        .i_precip    (i_precip),
        .o_quiet_sum (w_quiet_sum)
    );

    // pulse start and rain class
    logic        w_start;
    t_rain_class w_class;

    assign w_start = !i_snow_present
                  && (CMP_W'(w_quiet_sum) <= CMP_W'(r_quiet_limit))
                  && (i_precip > r_start_threshold);

    always_comb begin
        if (i_precip < r_medium_low) begin
            w_class = CLASS_LOW;
        end else if (i_precip <= r_medium_high) begin
            w_class = CLASS_MID;
        end else begin
            w_class = CLASS_HIGH;
        end
    end

    t_ring_ctl w_low_ctl, w_mid_ctl, w_high_ctl;

    assign w_low_ctl  = '{shift: w_accept, refill: w_accept && w_start && w_class == CLASS_LOW};
    assign w_mid_ctl  = '{shift: w_accept, refill: w_accept && w_start && w_class == CLASS_MID};
    assign w_high_ctl = '{shift: w_accept, refill: w_accept && w_start && w_class == CLASS_HIGH};

    logic [MULT_W-1:0] w_low_head, w_mid_head, w_high_head;

    rpm_decay_ring #(.DAYS(LOW_DAYS), .RING_CLASS(CLASS_LOW)) u_low (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_low_ctl), .o_head (w_low_head)
    );
    rpm_decay_ring #(.DAYS(MID_DAYS), .RING_CLASS(CLASS_MID)) u_mid (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_mid_ctl), .o_head (w_mid_head)
    );
    rpm_decay_ring #(.DAYS(HIGH_DAYS), .RING_CLASS(CLASS_HIGH)) u_high (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_high_ctl), .o_head (w_high_head)
    );

    // max of today's three slots
    logic [MULT_W-1:0] w_max_lm, w_max;

    assign w_max_lm = (w_low_head > w_mid_head) ? w_low_head : w_mid_head;
    assign w_max    = (w_high_head > w_max_lm) ? w_high_head : w_max_lm;

    // pulse countdown and result select
    logic [DAYS_W-1:0] r_pulse_days_left;
    logic [DAYS_W-1:0] n_pulse_days_left;
    logic [MULT_W-1:0] w_result;

    always_comb begin
        n_pulse_days_left = r_pulse_days_left;
        w_result          = ONE_Q12;
        if (i_snow_present) begin
            w_result = '0;
        end else if (w_start) begin
            w_result = w_max;
            case (w_class)
                CLASS_LOW:  n_pulse_days_left = DAYS_W'(LOW_DAYS - 1);
                CLASS_MID:  n_pulse_days_left = DAYS_W'(MID_DAYS - 1);
                CLASS_HIGH: n_pulse_days_left = DAYS_W'(HIGH_DAYS - 1);
                default:    n_pulse_days_left = r_pulse_days_left;
            endcase
        end else if (r_pulse_days_left != '0) begin
            w_result          = w_max;
            n_pulse_days_left = r_pulse_days_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_days_left <= '0;
        end else if (w_accept) begin
            r_pulse_days_left <= n_pulse_days_left;
        end
    end

    // output register
    logic [MULT_W-1:0] r_multiplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_multiplier <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_multiplier = r_multiplier;

endmodule

[sv/rpm_checker.sv]
// ---------------------------------------------------------------------------
// rpm_checker
// Port-level checks for the rain pulse multiplier, bound to the top level.
// ---------------------------------------------------------------------------
module rpm_checker
    import rpm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_snow_present,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [MULT_W-1:0]   o_multiplier
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // every accepted request yields a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request gave no result");

    // snow forces a zero multiplier
    a_snow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_snow_present) |=> (o_multiplier == '0))
        else $error("nonzero multiplier under snow");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_multiplier)))
        else $error("stalled result changed");

endmodule

bind rain_pulse_multiplier rpm_checker u_rpm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_snow_present (i_snow_present),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_multiplier   (o_multiplier)
);
